[sv/knnh_pkg.sv]
// shared types and constants of the knn heap block
`default_nettype none
package knnh_pkg;
   localparam int DIST_W = 40;
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   localparam int DEF_MAX_NEIGHBOURS = 16;
   localparam int DEF_MAX_FEATURES = 64;
   localparam int DEF_FEATURE_WIDTH = 16;

   localparam int POS_W = 6;
   localparam int K_W = 5;
   localparam int LABEL_W = 16;
   localparam int INDEX_W = 16;

   localparam logic [1:0] MODE_TEST = 2'd0;
   localparam logic [1:0] MODE_TRAIN = 2'd1;
   localparam logic [1:0] MODE_PASS = 2'd2;

   localparam logic REG_K = 1'b0;
   localparam logic REG_LABEL = 1'b1;

   typedef struct packed {
      logic m;
      logic [DIST_W-1:0] d;
   } heap_entry_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic [DIST_W-1:0] distance;
   } dist_status_type;
endpackage
`default_nettype wire

[sv/knnh_dist.sv]
// test vector memory and squared distance accumulator
`default_nettype none
module knnh_dist #(
   parameter int MAX_FEATURES = knnh_pkg::DEF_MAX_FEATURES,
   parameter int FEATURE_WIDTH = knnh_pkg::DEF_FEATURE_WIDTH
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic wr_valid,
   input wire logic el_valid,
   input wire logic clear,
   input wire logic [knnh_pkg::POS_W-1:0] pos,
   input wire logic [FEATURE_WIDTH-1:0] value,
   input wire logic last,
   output knnh_pkg::dist_status_type status
);
   localparam int FA = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int W = FEATURE_WIDTH;
   localparam int SQ_W = 2 * W;
   localparam int EXT_W = ((SQ_W > knnh_pkg::DIST_W) ? SQ_W : knnh_pkg::DIST_W) + 1;

   logic [W-1:0] tv [MAX_FEATURES];
   logic [W-1:0] tr_ff;
   logic [FA-1:0] addr;
   logic in_range;

   logic v1_ff, last1_ff, in1_ff;
   logic [W-1:0] val1_ff;
   logic v2_ff, last2_ff;
   logic [SQ_W-1:0] sq2_ff, sq2_in;
   logic [knnh_pkg::DIST_W-1:0] dsum_ff, dsum_in, dist_ff;
   logic done_ff;

   logic signed [W:0] diff;
   logic [W-1:0] mag;
   logic [EXT_W-1:0] sum_ext;
   logic [knnh_pkg::DIST_W-1:0] sum_sat;

   assign in_range = 32'(pos) < 32'(MAX_FEATURES);
   assign addr = FA'(pos);

   always_ff @(posedge clock) begin
      if (wr_valid && in_range) begin
         tv[addr] <= value;
      end
      tr_ff <= tv[addr];
   end

   // element difference and square
   always_comb begin
      diff = $signed({val1_ff[W-1], val1_ff}) - $signed({tr_ff[W-1], tr_ff});
      mag = diff[W] ? W'(-diff) : W'(diff);
      sq2_in = in1_ff ? SQ_W'(mag) * SQ_W'(mag) : '0;
   end

   // saturating accumulate
   always_comb begin
      sum_ext = EXT_W'(dsum_ff) + EXT_W'(sq2_ff);
      sum_sat = (sum_ext > EXT_W'(knnh_pkg::DIST_MAX)) ? knnh_pkg::DIST_MAX
                                                      : knnh_pkg::DIST_W'(sum_ext);
      dsum_in = dsum_ff;
      if (clear) begin
         dsum_in = '0;
      end else if (v2_ff) begin
         dsum_in = last2_ff ? '0 : sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         done_ff <= 1'b0;
         dsum_ff <= '0;
      end else begin
         v1_ff <= el_valid;
         v2_ff <= v1_ff;
         done_ff <= v2_ff && last2_ff;
         dsum_ff <= dsum_in;
      end
   end

   always_ff @(posedge clock) begin
      val1_ff <= value;
      last1_ff <= last;
      in1_ff <= in_range;
      last2_ff <= last1_ff;
      sq2_ff <= sq2_in;
      if (v2_ff && last2_ff) begin
         dist_ff <= sum_sat;
      end
   end

   assign status.busy = v1_ff | v2_ff | done_ff;
   assign status.done = done_ff;
   assign status.distance = dist_ff;
endmodule
`default_nettype wire

[sv/knnh_heap.sv]
// max-heap memory with sift-up and sift-down sequencer
`default_nettype none
module knnh_heap #(
   parameter int MAX_NEIGHBOURS = knnh_pkg::DEF_MAX_NEIGHBOURS
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic clear,
   input wire logic op_valid,
   input wire logic [knnh_pkg::DIST_W-1:0] op_distance,
   input wire logic op_match,
   input wire logic [knnh_pkg::K_W-1:0] neighbour_count,
   output logic busy,
   output logic done,
   output logic [knnh_pkg::K_W-1:0] match_total,
   output logic [1:0] match_change
);
   localparam int N = MAX_NEIGHBOURS;
   localparam int HA = (N > 1) ? $clog2(N) : 1;
   localparam int HF = $clog2(N + 1);
   localparam int CW = HF + 1;

   typedef enum logic [4:0] {
      H_IDLE = 5'b00001,
      H_UP = 5'b00010,
      H_ROOT = 5'b00100,
      H_DOWN = 5'b01000,
      H_LAST = 5'b10000
   } hstate_type;

   knnh_pkg::heap_entry_type mem [N];
   knnh_pkg::heap_entry_type rda_ff, rdb_ff, cur_ff, cur_in, wd;
   logic [HA-1:0] ra, rb, wa, hole_ff, hole_in, par;
   logic we;

   hstate_type state_ff, state_in;
   logic [HF-1:0] fill_ff, fill_in, mcount_ff, mcount_in, old_ff, old_in;
   logic done_ff, done_in;
   logic [HF-1:0] k_eff;
   logic [CW-1:0] lc, rc, tc, nl;
   logic pick_r;
   knnh_pkg::heap_entry_type td;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rda_ff <= mem[ra];
      rdb_ff <= mem[rb];
   end

   always_comb begin
      if (neighbour_count == '0) begin
         k_eff = HF'(1);
      end else if (32'(neighbour_count) > 32'(N)) begin
         k_eff = HF'(N);
      end else begin
         k_eff = HF'(neighbour_count);
      end
   end

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      mcount_in = mcount_ff;
      old_in = old_ff;
      hole_in = hole_ff;
      cur_in = cur_ff;
      done_in = 1'b0;
      ra = '0;
      rb = '0;
      we = 1'b0;
      wa = hole_ff;
      wd = cur_ff;
      par = HA'((hole_ff - HA'(1)) >> 1);
      lc = (CW'(hole_ff) << 1) + CW'(1);
      rc = lc + CW'(1);
      pick_r = (rc < CW'(fill_ff)) && (rdb_ff.d > rda_ff.d);
      tc = pick_r ? rc : lc;
      td = pick_r ? rdb_ff : rda_ff;
      nl = (tc << 1) + CW'(1);
      case (state_ff)
         H_IDLE: begin
            if (clear) begin
               fill_in = '0;
               mcount_in = '0;
            end else if (op_valid) begin
               cur_in = '{m: op_match, d: op_distance};
               old_in = mcount_ff;
               if (fill_ff < k_eff) begin
                  hole_in = HA'(fill_ff);
                  fill_in = fill_ff + HF'(1);
                  mcount_in = mcount_ff + HF'(op_match);
                  if (fill_ff == '0) begin
                     we = 1'b1;
                     wa = '0;
                     wd = '{m: op_match, d: op_distance};
                     done_in = 1'b1;
                  end else begin
                     ra = HA'((fill_ff - HF'(1)) >> 1);
                     state_in = H_UP;
                  end
               end else begin
                  ra = '0;
                  state_in = H_ROOT;
               end
            end
         end
         H_UP: begin
            we = 1'b1;
            if (cur_ff.d > rda_ff.d) begin
               wd = rda_ff;
               hole_in = par;
               if (par == '0) begin
                  state_in = H_LAST;
               end else begin
                  ra = HA'((par - HA'(1)) >> 1);
               end
            end else begin
               state_in = H_IDLE;
               done_in = 1'b1;
            end
         end
         H_ROOT: begin
            if (cur_ff.d < rda_ff.d) begin
               mcount_in = mcount_ff - HF'(rda_ff.m) + HF'(cur_ff.m);
               hole_in = '0;
               if (CW'(fill_ff) > CW'(1)) begin
                  ra = HA'(1);
                  rb = HA'(2);
                  state_in = H_DOWN;
               end else begin
                  we = 1'b1;
                  wa = '0;
                  state_in = H_IDLE;
                  done_in = 1'b1;
               end
            end else begin
               state_in = H_IDLE;
               done_in = 1'b1;
            end
         end
         H_DOWN: begin
            we = 1'b1;
            if (cur_ff.d < td.d) begin
               wd = td;
               hole_in = HA'(tc);
               if (nl < CW'(fill_ff)) begin
                  ra = HA'(nl);
                  rb = HA'(nl + CW'(1));
               end else begin
                  state_in = H_LAST;
               end
            end else begin
               state_in = H_IDLE;
               done_in = 1'b1;
            end
         end
         H_LAST: begin
            we = 1'b1;
            state_in = H_IDLE;
            done_in = 1'b1;
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         fill_ff <= '0;
         mcount_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         mcount_ff <= mcount_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      old_ff <= old_in;
      hole_ff <= hole_in;
      cur_ff <= cur_in;
   end

   assign busy = (state_ff != H_IDLE);
   assign done = done_ff;
   assign match_total = knnh_pkg::K_W'(mcount_ff);
   assign match_change = 2'(CW'(mcount_ff) - CW'(old_ff));

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(N)) else $error("heap fill above depth");
   a_match_bound: assert property (@(posedge clock) disable iff (reset)
      mcount_ff <= fill_ff) else $error("match count above fill");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> state_ff == H_IDLE) else $error("result while sifting");
   a_op_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == H_IDLE && op_valid && !clear) |=> (done_ff || state_ff != H_IDLE))
      else $error("heap request lost");
`endif
endmodule
`default_nettype wire

[sv/knn_heap_marginal_utility.sv]
// top level of the knn top-k heap block with marginal label utility
`default_nettype none
// usage
//   requests enter on start while busy is low; req_mode selects a test element
//   write, a training element, or a new permutation pass
//   a test element is written directly; a training element passes in turn
//   through the test vector memory read, the squaring multiplier and
//   the saturating accumulator
//   on the last element of a training vector the heap sequencer runs: a fill
//   sifts the new entry up (no moves for the first entry), a replace checks
//   the root and sifts the sample down from it (no moves when the sample
//   stays out), at most about log2 K moves; one result then appears on the
//   rsp_ ports with rsp_strobe high for one cycle
//   the heap memory has one write and two read ports with registered reads;
//   the write of a sift step never hits the entries read in that step
//   configuration goes through the apb port; registers, selected by paddr[2]:
//   0 neighbour count, 1 test label, to be written by the user only while
//   idle (not enforced by the block); reset clears the pass state, sets k to 1
//   and the label to 0; the test vector and heap memories hold garbage until
//   written; results cannot be stalled; the receiver must take every strobe
module knn_heap_marginal_utility #(
   parameter int MAX_NEIGHBOURS = knnh_pkg::DEF_MAX_NEIGHBOURS,
   parameter int MAX_FEATURES = knnh_pkg::DEF_MAX_FEATURES,
   parameter int FEATURE_WIDTH = knnh_pkg::DEF_FEATURE_WIDTH
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic [1:0] req_mode,
   input wire logic [knnh_pkg::POS_W-1:0] req_feature_pos,
   input wire logic [FEATURE_WIDTH-1:0] req_feature_value,
   input wire logic req_last_element,
   input wire logic [knnh_pkg::INDEX_W-1:0] req_sample_index,
   input wire logic [knnh_pkg::LABEL_W-1:0] req_sample_label,
   output logic rsp_strobe,
   output logic [knnh_pkg::INDEX_W-1:0] rsp_result_index,
   output logic [knnh_pkg::K_W-1:0] rsp_match_total,
   output logic signed [1:0] rsp_match_change,
   input wire logic psel,
   input wire logic penable,
   input wire logic pwrite,
   input wire logic [2:0] paddr,
   input wire logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   logic accept;
   logic wr_valid, el_valid, clear;
   logic [knnh_pkg::K_W-1:0] k_ff;
   logic [knnh_pkg::LABEL_W-1:0] label_ff;
   logic [knnh_pkg::INDEX_W-1:0] idx_ff;
   logic match_ff;
   logic heap_busy;
   logic [1:0] change;
   knnh_pkg::dist_status_type dstat;

   // request decode
   assign accept = start && !busy;
   assign wr_valid = accept && (req_mode == knnh_pkg::MODE_TEST);
   assign el_valid = accept && (req_mode == knnh_pkg::MODE_TRAIN);
   assign clear = accept && (req_mode == knnh_pkg::MODE_PASS);

   // sample tag and label compare captured with each training element
   always_ff @(posedge clock) begin
      if (el_valid) begin
         idx_ff <= req_sample_index;
         match_ff <= (req_sample_label == label_ff);
      end
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= knnh_pkg::K_W'(1);
         label_ff <= '0;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == knnh_pkg::REG_K) begin
            k_ff <= pwdata[knnh_pkg::K_W-1:0];
         end else begin
            label_ff <= pwdata[knnh_pkg::LABEL_W-1:0];
         end
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == knnh_pkg::REG_LABEL) ? 32'(label_ff) : 32'(k_ff);

   knnh_dist #(
      .MAX_FEATURES(MAX_FEATURES),
      .FEATURE_WIDTH(FEATURE_WIDTH)
   ) u_dist (
      .clock(clock),
      .reset(reset),
      .wr_valid(wr_valid),
      .el_valid(el_valid),
      .clear(clear),
      .pos(req_feature_pos),
      .value(req_feature_value),
      .last(req_last_element),
      .status(dstat)
   );

   // heap update starts as soon as a vector distance is final
   knnh_heap #(
      .MAX_NEIGHBOURS(MAX_NEIGHBOURS)
   ) u_heap (
      .clock(clock),
      .reset(reset),
      .clear(clear),
      .op_valid(dstat.done),
      .op_distance(dstat.distance),
      .op_match(match_ff),
      .neighbour_count(k_ff),
      .busy(heap_busy),
      .done(rsp_strobe),
      .match_total(rsp_match_total),
      .match_change(change)
   );

   // one request in flight at a time
   assign busy = dstat.busy || heap_busy;
   assign rsp_result_index = idx_ff;
   assign rsp_match_change = $signed(change);
endmodule
`default_nettype wire

[tb/knn_heap_marginal_utility_tb.sv]
// self-checking testbench of the knn top-k heap block with marginal label utility
`default_nettype none
module knn_heap_marginal_utility_tb;
   // mode code that the block must ignore
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [1:0] mode;
      logic [knnh_pkg::POS_W-1:0] pos;
      logic [15:0] value;
      logic last;
      logic [knnh_pkg::INDEX_W-1:0] index;
      logic [knnh_pkg::LABEL_W-1:0] label;
   } request_type;

   typedef struct packed {
      logic [knnh_pkg::INDEX_W-1:0] index;
      logic [knnh_pkg::K_W-1:0] total;
      logic signed [1:0] change;
   } utility_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_mode = '0;
   logic [knnh_pkg::POS_W-1:0] req_feature_pos = '0;
   logic [15:0] req_feature_value = '0;
   logic req_last_element = 1'b0;
   logic [knnh_pkg::INDEX_W-1:0] req_sample_index = '0;
   logic [knnh_pkg::LABEL_W-1:0] req_sample_label = '0;
   logic rsp_strobe;
   logic [knnh_pkg::INDEX_W-1:0] rsp_result_index;
   logic [knnh_pkg::K_W-1:0] rsp_match_total;
   logic signed [1:0] rsp_match_change;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   knn_heap_marginal_utility u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_feature_pos(req_feature_pos),
      .req_feature_value(req_feature_value), .req_last_element(req_last_element),
      .req_sample_index(req_sample_index), .req_sample_label(req_sample_label),
      .rsp_strobe(rsp_strobe), .rsp_result_index(rsp_result_index),
      .rsp_match_total(rsp_match_total), .rsp_match_change(rsp_match_change),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // queues: requests waiting for the driver, utilities waiting for the block
   request_type pending_requests[$];
   utility_type expected_utilities[$];
   request_type driven;
   logic taken = 1'b0;
   int gap_left = 0;
   logic gaps_on = 1'b1;
   int fail_count = 0;
   int cycle_count = 0;

   // predictor state, a copy of what the block should hold
   logic [15:0] tv_model[knnh_pkg::DEF_MAX_FEATURES];
   logic [knnh_pkg::DIST_W-1:0] sum_model = '0;
   logic [knnh_pkg::DIST_W-1:0] hd_model[knnh_pkg::DEF_MAX_NEIGHBOURS];
   logic hm_model[knnh_pkg::DEF_MAX_NEIGHBOURS];
   int fill_model = 0;
   int matches_model = 0;
   logic [knnh_pkg::K_W-1:0] k_cfg = 5'd1;
   logic [knnh_pkg::LABEL_W-1:0] label_cfg = '0;

   // generation side copies, so random vectors can land near the test point
   logic [15:0] tv_shadow[knnh_pkg::DEF_MAX_FEATURES];
   logic [knnh_pkg::LABEL_W-1:0] label_shadow = '0;

   function automatic void heap_swap(int a, int b);
      logic [knnh_pkg::DIST_W-1:0] d;
      logic m;
      d = hd_model[a]; m = hm_model[a];
      hd_model[a] = hd_model[b]; hm_model[a] = hm_model[b];
      hd_model[b] = d; hm_model[b] = m;
   endfunction

   // advance the predictor by one accepted request
   function automatic void predict_utility(request_type r);
      logic signed [17:0] diff;
      logic [63:0] sq;
      logic [63:0] total;
      int k, c, p, l, t, old;
      logic match;
      utility_type u;
      case (r.mode)
         knnh_pkg::MODE_PASS: begin
            fill_model = 0; matches_model = 0; sum_model = '0;
         end
         knnh_pkg::MODE_TEST: tv_model[r.pos] = r.value;
         knnh_pkg::MODE_TRAIN: begin
            diff = $signed({{2{r.value[15]}}, r.value}) -
                   $signed({{2{tv_model[r.pos][15]}}, tv_model[r.pos]});
            if (diff < 0) diff = -diff;
            sq = 64'(diff) * 64'(diff);
            total = 64'(sum_model) + sq;
            sum_model = (total > 64'(knnh_pkg::DIST_MAX)) ? knnh_pkg::DIST_MAX
                                                          : total[knnh_pkg::DIST_W-1:0];
            if (r.last) begin
               k = (k_cfg == 0) ? 1 : (k_cfg > knnh_pkg::DEF_MAX_NEIGHBOURS) ?
                   knnh_pkg::DEF_MAX_NEIGHBOURS : int'(k_cfg);
               match = (r.label == label_cfg);
               old = matches_model;
               if (fill_model < k) begin
                  hd_model[fill_model] = sum_model;
                  hm_model[fill_model] = match;
                  c = fill_model;
                  while (c > 0) begin
                     p = (c - 1) / 2;
                     if (!(hd_model[c] > hd_model[p])) break;
                     heap_swap(c, p);
                     c = p;
                  end
                  fill_model++;
                  matches_model += match;
               end else if (fill_model > 0 && sum_model < hd_model[0]) begin
                  matches_model = matches_model - hm_model[0] + match;
                  hd_model[0] = sum_model;
                  hm_model[0] = match;
                  // sift down, farther child wins, left on a tie
                  c = 0;
                  forever begin
                     l = 2 * c + 1;
                     if (l >= fill_model) break;
                     t = l;
                     if (l + 1 < fill_model && hd_model[l + 1] > hd_model[l]) t = l + 1;
                     if (!(hd_model[c] < hd_model[t])) break;
                     heap_swap(c, t);
                     c = t;
                  end
               end
               sum_model = '0;
               u.index = r.index;
               u.total = knnh_pkg::K_W'(matches_model);
               u.change = 2'(matches_model - old);
               expected_utilities.push_back(u);
            end
         end
         default: ;
      endcase
   endfunction

   // request generation
   task automatic queue_request(logic [1:0] mode, logic [knnh_pkg::POS_W-1:0] pos,
                                logic [15:0] value, logic last,
                                logic [knnh_pkg::INDEX_W-1:0] index,
                                logic [knnh_pkg::LABEL_W-1:0] label);
      request_type r;
      r = '{mode, pos, value, last, index, label};
      if (mode == knnh_pkg::MODE_TEST) tv_shadow[pos] = value;
      pending_requests.push_back(r);
   endtask

   // one training vector with random content; near vectors make distance ties likely
   task automatic queue_vector(int len);
      logic [knnh_pkg::INDEX_W-1:0] idx;
      logic [knnh_pkg::LABEL_W-1:0] lab;
      logic [knnh_pkg::POS_W-1:0] pos;
      logic [15:0] val;
      int style;
      idx = 16'($urandom);
      lab = ($urandom_range(0, 1) == 0) ? label_shadow :
            ($urandom_range(0, 2) == 0) ? 16'($urandom) : label_shadow ^ 16'd1;
      style = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
         pos = (len == knnh_pkg::DEF_MAX_FEATURES) ? knnh_pkg::POS_W'(i) :
               knnh_pkg::POS_W'($urandom_range(0, 63));
         case (style)
            0: val = 16'($urandom);
            1: val = tv_shadow[pos];
            default: val = tv_shadow[pos] + 16'($signed($urandom_range(0, 6)) - 3);
         endcase
         queue_request(knnh_pkg::MODE_TRAIN, pos, val, i == len - 1, idx, lab);
      end
   endtask

   // noise: stray test writes, spare mode, passes, a lone last element
   task automatic queue_noise();
      case ($urandom_range(0, 3))
         0: queue_request(knnh_pkg::MODE_TEST, knnh_pkg::POS_W'($urandom), 16'($urandom),
                          1'($urandom), 16'($urandom), 16'($urandom));
         1: queue_request(MODE_SPARE, knnh_pkg::POS_W'($urandom), 16'($urandom),
                          1'($urandom), 16'($urandom), 16'($urandom));
         2: queue_request(knnh_pkg::MODE_PASS, knnh_pkg::POS_W'($urandom), 16'($urandom),
                          1'($urandom), 16'($urandom), 16'($urandom));
         default: queue_vector(1);
      endcase
   endtask

   task automatic queue_random(int count);
      int target;
      target = pending_requests.size() + count;
      while (pending_requests.size() < target) begin
         if ($urandom_range(0, 9) == 0) queue_noise();
         else if ($urandom_range(0, 24) == 0) queue_vector(knnh_pkg::DEF_MAX_FEATURES);
         else queue_vector($urandom_range(1, 6));
      end
   endtask

   // wait until the block is idle with nothing outstanding
   task automatic wait_idle();
      wait (pending_requests.size() == 0 && !start && expected_utilities.size() == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic reg_sel, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= {reg_sel, 2'b00}; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (reg_sel == knnh_pkg::REG_K) k_cfg = value[knnh_pkg::K_W-1:0];
      else begin
         label_cfg = value[knnh_pkg::LABEL_W-1:0];
         label_shadow = value[knnh_pkg::LABEL_W-1:0];
      end
   endtask

   // driver: accept at the rising edge, present the next request at the falling edge
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         predict_utility(driven);
         taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      logic holding;
      if (!reset) begin
         holding = start;
         if (taken) begin
            taken = 1'b0;
            holding = 1'b0;
            if ($urandom_range(0, 39) == 0) gaps_on = ~gaps_on;
            gap_left = gaps_on ? $urandom_range(0, 14) : 0;
         end
         if (holding) begin
            // request still waiting for acceptance
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            driven = pending_requests.pop_front();
            req_mode <= driven.mode;
            req_feature_pos <= driven.pos;
            req_feature_value <= driven.value;
            req_last_element <= driven.last;
            req_sample_index <= driven.index;
            req_sample_label <= driven.label;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobe is checked against the oldest prediction
   always @(posedge clock) begin
      utility_type want;
      if (!reset && rsp_strobe) begin
         if (expected_utilities.size() == 0) begin
            $display("%0t unexpected result: index %0d total %0d change %0d", $time,
                     rsp_result_index, rsp_match_total, rsp_match_change);
            fail_count++;
         end else begin
            want = expected_utilities.pop_front();
            if (rsp_result_index !== want.index) begin
               $display("%0t result_index expected %0d actual %0d", $time,
                        want.index, rsp_result_index);
               fail_count++;
            end
            if (rsp_match_total !== want.total) begin
               $display("%0t match_total expected %0d actual %0d", $time,
                        want.total, rsp_match_total);
               fail_count++;
            end
            if (rsp_match_change !== want.change) begin
               $display("%0t match_change expected %0d actual %0d", $time,
                        want.change, rsp_match_change);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // fill the whole test vector first, extremes included
      for (int i = 0; i < knnh_pkg::DEF_MAX_FEATURES; i++)
         queue_request(knnh_pkg::MODE_TEST, knnh_pkg::POS_W'(i),
                       (i == 0) ? 16'h7fff : (i == 1) ? 16'h8000 : (i == 2) ? 16'h0000 :
                       16'($urandom), 1'b0, '0, '0);
      // largest possible element distance, both signs
      queue_request(knnh_pkg::MODE_TRAIN, 6'd0, 16'h8000, 1'b1, 16'hffff, 16'hffff);
      queue_request(knnh_pkg::MODE_TRAIN, 6'd1, 16'h7fff, 1'b1, 16'h0000, 16'h0000);
      // k is 1: nearer replaces, a tie does not
      queue_request(knnh_pkg::MODE_TRAIN, 6'd2, 16'h0000, 1'b1, 16'd5, 16'h0000);
      queue_request(knnh_pkg::MODE_TRAIN, 6'd2, 16'h0000, 1'b1, 16'd6, 16'h0001);
      // ignored mode, then a new pass
      queue_request(MODE_SPARE, 6'h3f, 16'hffff, 1'b1, 16'hffff, 16'hffff);
      queue_request(knnh_pkg::MODE_PASS, 6'h3f, 16'hffff, 1'b1, 16'hffff, 16'hffff);
      queue_request(knnh_pkg::MODE_TRAIN, 6'd63, tv_shadow[63], 1'b0, 16'd7, 16'd0);
      queue_request(knnh_pkg::MODE_TRAIN, 6'd2, 16'h0001, 1'b1, 16'd7, 16'd0);
      queue_random(300);
      wait_idle();

      // largest k with an unusual label
      csr_write(knnh_pkg::REG_LABEL, 32'h0000_ffff);
      csr_write(knnh_pkg::REG_K, 32'd16);
      queue_request(knnh_pkg::MODE_PASS, '0, '0, 1'b0, '0, '0);
      queue_random(350);
      wait_idle();

      // k above the heap size saturates; heap kept across the change
      csr_write(knnh_pkg::REG_K, 32'd31);
      queue_random(250);
      wait_idle();

      // k lowered mid-pass: fill stays, only replacements follow
      csr_write(knnh_pkg::REG_K, 32'd3);
      csr_write(knnh_pkg::REG_LABEL, 32'h0000_0000);
      queue_random(250);
      wait_idle();

      // zero acts as one
      csr_write(knnh_pkg::REG_K, 32'd0);
      queue_request(knnh_pkg::MODE_PASS, '0, '0, 1'b0, '0, '0);
      queue_random(250);
      wait_idle();

      csr_write(knnh_pkg::REG_K, 32'd7);
      csr_write(knnh_pkg::REG_LABEL, 32'h0000_a5a5);
      queue_request(knnh_pkg::MODE_PASS, '0, '0, 1'b0, '0, '0);
      queue_random(250);
      wait_idle();

      csr_write(knnh_pkg::REG_K, 32'd16);
      queue_random(250);
      wait_idle();

      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
`default_nettype wire
